// ===== sv/crc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_pkg
// Shared constants for the triangle circumcircle pipeline: fixed-point
// shifts, divider quotient length and the saturation limits of the results.
// ----------------------------------------------------------------------------
package crc_pkg;

    localparam int CENTER_SHIFT = 7;
    localparam int RADIUS_SHIFT = 14;
    localparam int BASE_SHIFT   = 8;
    localparam int QUO_BITS     = 34;

    localparam logic [31:0] CEN_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] CEN_MIN = 32'h8000_0000;
    localparam logic [31:0] RAD_MAX = 32'hFFFF_FFFF;

endpackage

// ===== sv/crc_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_sqrt
// Pipelined integer square root, one root bit per stage, rounded down.
// ----------------------------------------------------------------------------
module crc_sqrt #(
    parameter int MB = 64,
    parameter int SB = 32,
    parameter int XB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [MB-1:0] in_val,
    input  logic [XB-1:0] in_side,
    output logic          out_valid,
    output logic [SB-1:0] out_root,
    output logic [XB-1:0] out_side
);

    localparam int TW = MB + 2;

    logic          vld_reg  [0:SB-1];
    logic [MB-1:0] rem_reg  [0:SB-1];
    logic [SB-1:0] root_reg [0:SB-1];
    logic [XB-1:0] side_reg [0:SB-1];

    for (genvar k = 0; k < SB; k++) begin : g_stage
        localparam int I = SB - 1 - k;
        logic          cur_vld;
        logic [MB-1:0] cur_rem;
        logic [SB-1:0] cur_root;
        logic [XB-1:0] cur_side;
        logic [TW-1:0] trial;
        logic          take;

        if (k == 0) begin : g_first
            assign cur_vld  = in_valid;
            assign cur_rem  = in_val;
            assign cur_root = '0;
            assign cur_side = in_side;
        end
        else begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_root = root_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign trial = (TW'(cur_root) << (I + 1)) | (TW'(1) << (2 * I));
        assign take  = TW'(cur_rem) >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= cur_side;
            if (take)
            begin
                rem_reg[k]  <= MB'(TW'(cur_rem) - trial);
                root_reg[k] <= cur_root | (SB'(1) << I);
            end
            else
            begin
                rem_reg[k]  <= cur_rem;
                root_reg[k] <= cur_root;
            end
        end
    end

    assign out_valid = vld_reg[SB-1];
    assign out_root  = root_reg[SB-1];
    assign out_side  = side_reg[SB-1];

endmodule

// ===== sv/crc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag when the quotient does not fit and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module crc_div #(
    parameter int NB = 64,
    parameter int DB = 32,
    parameter int QB = 32,
    parameter int XB = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [NB-1:0] in_num,
    input  logic [DB-1:0] in_den,
    input  logic [XB-1:0] in_side,
    output logic          out_valid,
    output logic [QB-1:0] out_quo,
    output logic          out_remnz,
    output logic          out_ovf,
    output logic [XB-1:0] out_side
);

    localparam int CW = ((NB > DB + QB) ? NB : DB + QB) + 1;

    logic          vld0_reg;
    logic [NB-1:0] num0_reg;
    logic [DB-1:0] den0_reg;
    logic          ovf0_reg;
    logic [XB-1:0] side0_reg;

    logic          vld_reg  [0:QB-1];
    logic [NB-1:0] rem_reg  [0:QB-1];
    logic [DB-1:0] den_reg  [0:QB-1];
    logic [QB-1:0] quo_reg  [0:QB-1];
    logic          ovf_reg  [0:QB-1];
    logic [XB-1:0] side_reg [0:QB-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
        end
        else
        begin
            vld0_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num0_reg  <= in_num;
        den0_reg  <= in_den;
        ovf0_reg  <= CW'(in_num) >= (CW'(in_den) << QB);
        side0_reg <= in_side;
    end

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int I = QB - 1 - k;
        logic          cur_vld;
        logic [NB-1:0] cur_rem;
        logic [DB-1:0] cur_den;
        logic [QB-1:0] cur_quo;
        logic          cur_ovf;
        logic [XB-1:0] cur_side;
        logic [CW-1:0] sub;
        logic          take;

        if (k == 0) begin : g_first
            assign cur_vld  = vld0_reg;
            assign cur_rem  = num0_reg;
            assign cur_den  = den0_reg;
            assign cur_quo  = '0;
            assign cur_ovf  = ovf0_reg;
            assign cur_side = side0_reg;
        end
        else begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur_rem  = rem_reg[k-1];
            assign cur_den  = den_reg[k-1];
            assign cur_quo  = quo_reg[k-1];
            assign cur_ovf  = ovf_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        assign sub  = CW'(cur_den) << I;
        assign take = CW'(cur_rem) >= sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[k]  <= cur_den;
            ovf_reg[k]  <= cur_ovf;
            side_reg[k] <= cur_side;
            if (take)
            begin
                rem_reg[k] <= NB'(CW'(cur_rem) - sub);
                quo_reg[k] <= cur_quo | (QB'(1) << I);
            end
            else
            begin
                rem_reg[k] <= cur_rem;
                quo_reg[k] <= cur_quo;
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quo   = quo_reg[QB-1];
    assign out_remnz = rem_reg[QB-1] != '0;
    assign out_ovf   = ovf_reg[QB-1];
    assign out_side  = side_reg[QB-1];

endmodule

// ===== sv/triangle_circumcircle.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle
// Circumcenter and circumradius of a 2D triangle in exact fixed point.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy stays low, so a
// new triangle may be issued each clock. The pipeline consists of eight
// arithmetic stages, the one-bit-per-stage square root of 3*COORD_BITS + 11
// stages and the dividers of 35 stages each (an input register and 34
// quotient stages), followed by the registered done and result outputs.
// The receiver cannot stall and must take every result.
module triangle_circumcircle #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] ax,
    input  logic signed [COORD_BITS-1:0] ay,
    input  logic signed [COORD_BITS-1:0] bx,
    input  logic signed [COORD_BITS-1:0] by,
    input  logic signed [COORD_BITS-1:0] cx,
    input  logic signed [COORD_BITS-1:0] cy,
    output logic                         done,
    output logic signed [31:0]           center_x,
    output logic signed [31:0]           center_y,
    output logic [31:0]                  radius,
    output logic                         degenerate,
    output logic                         saturated
);

    import crc_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int UW  = W + 1;
    localparam int PW  = 2 * UW;
    localparam int DW  = 2 * W + 2;
    localparam int NW  = 3 * W + 4;
    localparam int NM  = 3 * W + 3;
    localparam int H   = (NM + 1) / 2;
    localparam int HB  = NM - H;
    localparam int MB  = 2 * NM + 1 + RADIUS_SHIFT;
    localparam int SB  = (MB + 1) / 2;
    localparam int CNB = NM + CENTER_SHIFT;
    localparam int TW  = QUO_BITS + 3;

    typedef struct packed {
        logic [NM-1:0]       anx;
        logic [NM-1:0]       any;
        logic [DW-1:0]       ad;
        logic                xneg;
        logic                yneg;
        logic                deg;
        logic signed [W-1:0] bx0;
        logic signed [W-1:0] by0;
    } side_t;

    typedef struct packed {
        logic                neg;
        logic signed [W-1:0] base;
    } cside_t;

    logic [7:0] vld_reg;

    // stage 1
    logic signed [UW-1:0] ux_reg, uy_reg, vx_reg, vy_reg;
    logic signed [W-1:0]  ax1_reg, ay1_reg;
    // stage 2
    logic signed [PW-1:0] p1_reg, p2_reg, uxx_reg, uyy_reg, vxx_reg, vyy_reg;
    logic signed [UW-1:0] ux2_reg, uy2_reg, vx2_reg, vy2_reg;
    logic signed [W-1:0]  ax2_reg, ay2_reg;
    // stage 3
    logic signed [DW:0]   dv3_reg;
    logic [DW-1:0]        u2_reg, v2_reg;
    logic signed [UW-1:0] ux3_reg, uy3_reg, vx3_reg, vy3_reg;
    logic signed [W-1:0]  ax3_reg, ay3_reg;
    // stage 4
    logic signed [NW-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [DW:0]   dv4_reg;
    logic signed [W-1:0]  ax4_reg, ay4_reg;
    // stage 5
    logic signed [NW-1:0] nx_reg, ny_reg;
    logic signed [DW:0]   dv5_reg;
    logic signed [W-1:0]  ax5_reg, ay5_reg;
    // stage 6..8
    side_t                s6_reg, s7_reg, s8_reg;
    logic [2*H-1:0]       xll_reg, yll_reg, xhl_reg, yhl_reg;
    logic [2*HB-1:0]      xhh_reg, yhh_reg;
    logic [MB-1:0]        m_reg;

    logic                 sq_valid;
    logic [SB-1:0]        sq_root;
    logic [$bits(side_t)-1:0] sq_side_bits;
    side_t                sq_side;

    logic                 rd_valid, rd_remnz, rd_ovf, rd_deg;
    logic [QUO_BITS-1:0]  rd_quo;
    logic                 xd_valid, xd_remnz, xd_ovf;
    logic [QUO_BITS-1:0]  xd_quo;
    logic [$bits(cside_t)-1:0] xd_side;
    logic                 yd_valid, yd_remnz, yd_ovf;
    logic [QUO_BITS-1:0]  yd_quo;
    logic [$bits(cside_t)-1:0] yd_side;

    logic                 done_reg;
    logic [31:0]          cx_reg, cy_reg, rad_reg;
    logic                 deg_reg, sat_reg;

    logic [31:0]          cx_next, cy_next, rad_next;
    logic                 cx_sat, cy_sat, rad_sat;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[6:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        ux_reg  <= $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
        uy_reg  <= $signed({by[W-1], by}) - $signed({ay[W-1], ay});
        vx_reg  <= $signed({cx[W-1], cx}) - $signed({ax[W-1], ax});
        vy_reg  <= $signed({cy[W-1], cy}) - $signed({ay[W-1], ay});
        ax1_reg <= ax;
        ay1_reg <= ay;

        p1_reg  <= ux_reg * vy_reg;
        p2_reg  <= vx_reg * uy_reg;
        uxx_reg <= ux_reg * ux_reg;
        uyy_reg <= uy_reg * uy_reg;
        vxx_reg <= vx_reg * vx_reg;
        vyy_reg <= vy_reg * vy_reg;
        ux2_reg <= ux_reg;
        uy2_reg <= uy_reg;
        vx2_reg <= vx_reg;
        vy2_reg <= vy_reg;
        ax2_reg <= ax1_reg;
        ay2_reg <= ay1_reg;

        dv3_reg <= $signed({p1_reg[PW-1], p1_reg}) - $signed({p2_reg[PW-1], p2_reg});
        u2_reg  <= DW'($unsigned(uxx_reg)) + DW'($unsigned(uyy_reg));
        v2_reg  <= DW'($unsigned(vxx_reg)) + DW'($unsigned(vyy_reg));
        ux3_reg <= ux2_reg;
        uy3_reg <= uy2_reg;
        vx3_reg <= vx2_reg;
        vy3_reg <= vy2_reg;
        ax3_reg <= ax2_reg;
        ay3_reg <= ay2_reg;

        t1_reg  <= $signed({1'b0, u2_reg}) * vy3_reg;
        t2_reg  <= $signed({1'b0, v2_reg}) * uy3_reg;
        t3_reg  <= $signed({1'b0, v2_reg}) * ux3_reg;
        t4_reg  <= $signed({1'b0, u2_reg}) * vx3_reg;
        dv4_reg <= dv3_reg;
        ax4_reg <= ax3_reg;
        ay4_reg <= ay3_reg;

        nx_reg  <= t1_reg - t2_reg;
        ny_reg  <= t3_reg - t4_reg;
        dv5_reg <= dv4_reg;
        ax5_reg <= ax4_reg;
        ay5_reg <= ay4_reg;

        s6_reg.anx  <= NM'(nx_reg[NW-1] ? -nx_reg : nx_reg);
        s6_reg.any  <= NM'(ny_reg[NW-1] ? -ny_reg : ny_reg);
        s6_reg.ad   <= DW'(dv5_reg[DW] ? -dv5_reg : dv5_reg);
        s6_reg.xneg <= nx_reg[NW-1] ^ dv5_reg[DW];
        s6_reg.yneg <= ny_reg[NW-1] ^ dv5_reg[DW];
        s6_reg.deg  <= dv5_reg == '0;
        s6_reg.bx0  <= ax5_reg;
        s6_reg.by0  <= ay5_reg;

        xll_reg <= s6_reg.anx[H-1:0] * s6_reg.anx[H-1:0];
        xhl_reg <= (2*H)'(s6_reg.anx[NM-1:H] * s6_reg.anx[H-1:0]);
        xhh_reg <= s6_reg.anx[NM-1:H] * s6_reg.anx[NM-1:H];
        yll_reg <= s6_reg.any[H-1:0] * s6_reg.any[H-1:0];
        yhl_reg <= (2*H)'(s6_reg.any[NM-1:H] * s6_reg.any[H-1:0]);
        yhh_reg <= s6_reg.any[NM-1:H] * s6_reg.any[NM-1:H];
        s7_reg  <= s6_reg;

        m_reg   <= ((MB'(xhh_reg) << (2 * H)) + (MB'(xhl_reg) << (H + 1)) + MB'(xll_reg)
                  + (MB'(yhh_reg) << (2 * H)) + (MB'(yhl_reg) << (H + 1)) + MB'(yll_reg))
                  << RADIUS_SHIFT;
        s8_reg  <= s7_reg;
    end

    crc_sqrt #(
        .MB (MB),
        .SB (SB),
        .XB ($bits(side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[7]),
        .in_val    (m_reg),
        .in_side   (s8_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side_bits)
    );

    assign sq_side = side_t'(sq_side_bits);

    crc_div #(
        .NB (SB),
        .DB (DW),
        .QB (QUO_BITS),
        .XB (1)
    ) u_div_r (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    (sq_root),
        .in_den    (sq_side.ad),
        .in_side   (sq_side.deg),
        .out_valid (rd_valid),
        .out_quo   (rd_quo),
        .out_remnz (rd_remnz),
        .out_ovf   (rd_ovf),
        .out_side  (rd_deg)
    );

    crc_div #(
        .NB (CNB),
        .DB (DW),
        .QB (QUO_BITS),
        .XB ($bits(cside_t))
    ) u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    ({sq_side.anx, CENTER_SHIFT'(0)}),
        .in_den    (sq_side.ad),
        .in_side   ({sq_side.xneg, sq_side.bx0}),
        .out_valid (xd_valid),
        .out_quo   (xd_quo),
        .out_remnz (xd_remnz),
        .out_ovf   (xd_ovf),
        .out_side  (xd_side)
    );

    crc_div #(
        .NB (CNB),
        .DB (DW),
        .QB (QUO_BITS),
        .XB ($bits(cside_t))
    ) u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_num    ({sq_side.any, CENTER_SHIFT'(0)}),
        .in_den    (sq_side.ad),
        .in_side   ({sq_side.yneg, sq_side.by0}),
        .out_valid (yd_valid),
        .out_quo   (yd_quo),
        .out_remnz (yd_remnz),
        .out_ovf   (yd_ovf),
        .out_side  (yd_side)
    );

    function automatic logic [32:0] center_fix(
        input logic [QUO_BITS-1:0]       q,
        input logic                      rz,
        input logic                      ovf,
        input logic [$bits(cside_t)-1:0] sd
    );
        cside_t                 c;
        logic [QUO_BITS:0]      mag;
        logic signed [TW-1:0]   val;
        logic signed [TW-1:0]   tot;
        logic [32:0]            res;
        c   = cside_t'(sd);
        mag = {1'b0, q} + (QUO_BITS+1)'(c.neg & rz);
        val = $signed(TW'(mag));
        if (c.neg)
        begin
            val = -val;
        end
        tot = val + ($signed(TW'(c.base)) <<< BASE_SHIFT);
        if (ovf)
        begin
            res = {1'b1, c.neg ? CEN_MIN : CEN_MAX};
        end
        else if (tot > $signed(TW'(CEN_MAX)))
        begin
            res = {1'b1, CEN_MAX};
        end
        else if (tot < -$signed(TW'(CEN_MIN)))
        begin
            res = {1'b1, CEN_MIN};
        end
        else
        begin
            res = {1'b0, tot[31:0]};
        end
        return res;
    endfunction

    assign {cx_sat, cx_next} = center_fix(xd_quo, xd_remnz, xd_ovf, xd_side);
    assign {cy_sat, cy_next} = center_fix(yd_quo, yd_remnz, yd_ovf, yd_side);
    assign rad_sat  = rd_ovf || (rd_quo[QUO_BITS-1:32] != '0);
    assign rad_next = rad_sat ? RAD_MAX : rd_quo[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            rad_reg  <= '0;
            deg_reg  <= 1'b0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= rd_valid && xd_valid && yd_valid;
            if (rd_valid)
            begin
                deg_reg <= rd_deg;
                if (rd_deg)
                begin
                    cx_reg  <= '0;
                    cy_reg  <= '0;
                    rad_reg <= '0;
                    sat_reg <= 1'b0;
                end
                else
                begin
                    cx_reg  <= cx_next;
                    cy_reg  <= cy_next;
                    rad_reg <= rad_next;
                    sat_reg <= cx_sat || cy_sat || rad_sat || rd_remnz & 1'b0;
                end
            end
        end
    end

    assign done       = done_reg;
    assign center_x   = $signed(cx_reg);
    assign center_y   = $signed(cy_reg);
    assign radius     = rad_reg;
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

endmodule

// ===== sv/crc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc_checker
// Port-level checks for the circumcircle pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module crc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        busy,
    input logic        done,
    input logic [31:0] center_x,
    input logic [31:0] center_y,
    input logic [31:0] radius,
    input logic        degenerate,
    input logic        saturated
);

    import crc_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> center_x == 32'd0 && center_y == 32'd0
                               && radius == 32'd0 && !saturated)
        else $error("degenerate result not cleared");

    a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> center_x == CEN_MAX || center_x == CEN_MIN
                              || center_y == CEN_MAX || center_y == CEN_MIN
                              || radius == RAD_MAX)
        else $error("saturated without a clamped field");

endmodule

bind triangle_circumcircle crc_checker u_crc_checker (.*);

// ===== tb/triangle_circumcircle_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_circumcircle_tb
// Self-checking bench for the circumcircle pipeline. A directed table covers
// coincident, collinear, extreme and saturating triangles, then about 1600
// random triangles follow under several idle patterns. Every result is
// compared field by field against a typed expectation from the table or an exact wide-integer circle model.
// ----------------------------------------------------------------------------
module triangle_circumcircle_tb;

    import crc_pkg::*;

    localparam int  COORD_BITS = 16;
    localparam int  RAND_COUNT = 1600;
    localparam int  IDLE_LIMIT = 4000;
    localparam int  DRAIN_WAIT = 160;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [255:0]          wide_t;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy;
    } tri_t;

    typedef struct {
        logic signed [31:0] cen_x;
        logic signed [31:0] cen_y;
        logic [31:0]        rad;
        logic               degen;
        logic               sat;
    } circle_t;

    typedef struct {
        tri_t    t;
        bit      typed;
        circle_t c;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    coord_t             ax, ay, bx, by, cx, cy;
    logic               done;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic [31:0]        radius;
    logic               degenerate;
    logic               saturated;

    circle_t circles_due[$];
    bit      typed_now;
    circle_t typed_circle;
    bit      failed;
    int      idle_cycles;

    triangle_circumcircle #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .done       (done),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius     (radius),
        .degenerate (degenerate),
        .saturated  (saturated)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (q * d != n && ((n < 0) != (d < 0)))
            q = q - 1;
        return q;
    endfunction

    function automatic logic [31:0] clamp_center(wide_t v, ref bit sat);
        if (v > wide_t'($signed(CEN_MAX)))
        begin
            sat = 1'b1;
            return CEN_MAX;
        end
        if (v < wide_t'($signed(CEN_MIN)))
        begin
            sat = 1'b1;
            return CEN_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] root_floor(logic [63:0] x);
        logic [31:0] res;
        logic [31:0] trial;
        res = '0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = res | (32'd1 << b);
            if ({32'd0, trial} * {32'd0, trial} <= x)
                res = trial;
        end
        return res;
    endfunction

    function automatic circle_t circle_of(tri_t t);
        wide_t   ux, uy, vx, vy, dv, u2, v2, nx, ny, s, rq;
        bit      sat;
        circle_t o;
        o = '{default: '0};
        sat = 1'b0;
        ux = wide_t'(t.bx) - wide_t'(t.ax);
        uy = wide_t'(t.by) - wide_t'(t.ay);
        vx = wide_t'(t.cx) - wide_t'(t.ax);
        vy = wide_t'(t.cy) - wide_t'(t.ay);
        dv = ux * vy - vx * uy;
        if (dv == 0)
        begin
            o.degen = 1'b1;
            return o;
        end
        u2 = ux * ux + uy * uy;
        v2 = vx * vx + vy * vy;
        nx = u2 * vy - v2 * uy;
        ny = ux * v2 - vx * u2;
        o.cen_x = clamp_center(floor_div(nx <<< CENTER_SHIFT, dv)
                               + (wide_t'(t.ax) <<< BASE_SHIFT), sat);
        o.cen_y = clamp_center(floor_div(ny <<< CENTER_SHIFT, dv)
                               + (wide_t'(t.ay) <<< BASE_SHIFT), sat);
        s  = (nx * nx + ny * ny) <<< RADIUS_SHIFT;
        rq = s / (dv * dv);
        if (rq > wide_t'(64'hFFFF_FFFF_FFFF_FFFF))
        begin
            sat = 1'b1;
            o.rad = RAD_MAX;
        end
        else
        begin
            o.rad = root_floor(rq[63:0]);
        end
        o.sat = sat;
        return o;
    endfunction

    function automatic coord_t pick_edge();
        case ($urandom_range(0, 4))
            0: return coord_t'(-32768);
            1: return coord_t'(-1);
            2: return coord_t'(0);
            3: return coord_t'(1);
            default: return coord_t'(32767);
        endcase
    endfunction

    function automatic coord_t near(int lim);
        return coord_t'($urandom_range(0, 2 * lim) - lim);
    endfunction

    function automatic tri_t rand_tri();
        tri_t t;
        int   k;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            t = '{near(2048), near(2048), near(2048), near(2048), near(2048), near(2048)};
        end
        else if (pick < 65)
        begin
            t = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
        end
        else if (pick < 75)
        begin
            k = $urandom_range(0, 6) - 3;
            t.ax = near(4000);
            t.ay = near(4000);
            t.bx = t.ax + near(1000);
            t.by = t.ay + near(1000);
            t.cx = t.ax + coord_t'(k) * (t.bx - t.ax);
            t.cy = t.ay + coord_t'(k) * (t.by - t.ay);
        end
        else if (pick < 83)
        begin
            t = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
            t.cx = t.ax;
            t.cy = t.ay;
        end
        else if (pick < 93)
        begin
            t.ax = near(32000);
            t.ay = near(32000);
            t.bx = -t.ax;
            t.by = -t.ay;
            t.cx = t.bx + near(2);
            t.cy = t.by + near(2);
        end
        else
        begin
            t = '{pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge(), pick_edge()};
        end
        return t;
    endfunction

    task automatic issue(tri_t t, bit typed, circle_t c);
        @(negedge clk);
        ax <= t.ax;
        ay <= t.ay;
        bx <= t.bx;
        by <= t.by;
        cx <= t.cx;
        cy <= t.cy;
        typed_now <= typed;
        typed_circle <= c;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic hold_off(int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1)
            @(negedge clk);
    endtask

    // queue the prediction for each accepted request
    always @(posedge clk)
    begin
        if (rst_n && start && busy === 1'b0)
        begin
            if (typed_now)
                circles_due.push_back(typed_circle);
            else
                circles_due.push_back(circle_of('{ax, ay, bx, by, cx, cy}));
        end
    end

    always @(posedge clk)
    begin
        circle_t e;
        if (rst_n && done === 1'b1)
        begin
            if (circles_due.size() == 0)
            begin
                $error("result with no request pending");
                failed = 1'b1;
            end
            else
            begin
                e = circles_due.pop_front();
                if (center_x !== e.cen_x)
                begin
                    $error("center_x expected %0d got %0d", e.cen_x, center_x);
                    failed = 1'b1;
                end
                if (center_y !== e.cen_y)
                begin
                    $error("center_y expected %0d got %0d", e.cen_y, center_y);
                    failed = 1'b1;
                end
                if (radius !== e.rad)
                begin
                    $error("radius expected %0d got %0d", e.rad, radius);
                    failed = 1'b1;
                end
                if (degenerate !== e.degen)
                begin
                    $error("degenerate expected %0d got %0d", e.degen, degenerate);
                    failed = 1'b1;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %0d got %0d", e.sat, saturated);
                    failed = 1'b1;
                end
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        row_t    rows[$];
        circle_t none;
        circle_t degen_c;
        circle_t unit_c;
        int      idle_pct;
        none    = '{default: '0};
        degen_c = '{default: '0};
        degen_c.degen = 1'b1;
        unit_c  = '{32'sd32768, 32'sd32768, 32'd46340, 1'b0, 1'b0};

        rows = '{
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1'b1, degen_c},
            '{'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768, -16'sd32768}, 1'b1, degen_c},
            '{'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                16'sd32767, 16'sd32767}, 1'b1, degen_c},
            '{'{-16'sd32768, -16'sd32768, 16'sd0, 16'sd0,
                16'sd32767, 16'sd32767}, 1'b0, none},
            '{'{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd0, 16'sd256}, 1'b1, unit_c},
            '{'{16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0}, 1'b0, none},
            '{'{16'sd10, 16'sd20, 16'sd10, 16'sd20, 16'sd300, 16'sd7}, 1'b1, degen_c},
            '{'{-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
                -16'sd32768, 16'sd32767}, 1'b0, none},
            '{'{16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767,
                16'sd32767, -16'sd32768}, 1'b0, none},
            '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                16'sd32767, 16'sd32766}, 1'b0, none},
            '{'{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                16'sd32766, -16'sd32768}, 1'b0, none},
            '{'{16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, none},
            '{'{-16'sd1, -16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd1}, 1'b0, none},
            '{'{16'sd0, 16'sd0, 16'sd32767, 16'sd1, -16'sd32768, 16'sd0}, 1'b0, none},
            '{'{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                16'sd0, 16'sd0}, 1'b0, none},
            '{'{16'sd100, 16'sd100, 16'sd100, 16'sd356, 16'sd356, 16'sd100}, 1'b0, none}
        };

        failed      = 1'b0;
        idle_cycles = 0;
        typed_now   = 1'b0;
        typed_circle = none;
        start = 1'b0;
        ax = '0;
        ay = '0;
        bx = '0;
        by = '0;
        cx = '0;
        cy = '0;
        rst_n = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            issue(rows[i].t, rows[i].typed, rows[i].c);

        // hold until the pipeline has drained
        @(negedge clk);
        start <= 1'b0;
        wait (circles_due.size() == 0);

        for (int n = 0; n < RAND_COUNT; n++)
        begin
            case (n / (RAND_COUNT / 4))
                1: idle_pct = 58;
                3: idle_pct = 14;
                default: idle_pct = 0;
            endcase
            while ($urandom_range(1, 100) <= idle_pct)
                hold_off(1);
            issue(rand_tri(), 1'b0, none);
        end
        @(negedge clk);
        start <= 1'b0;

        wait (circles_due.size() == 0);
        repeat (DRAIN_WAIT)
            @(posedge clk);
        if (!failed)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
